[rtl/core/iete_pkg.sv]
package iete_pkg;

  // Field widths of the channels and the configuration registers.
  localparam int CLOCK_W    = 63;
  localparam int PASSED_W   = 63;
  localparam int TSP_W      = 20;
  localparam int CNT_W      = 14;
  localparam int MINS_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Width of the scaled ratio: a 20-bit quotient times a 14-bit step count.
  localparam int SCALE_W = TSP_W + CNT_W;

  localparam int TIME_BITS_DEF = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP      = 2'd2;

  // Reset values of the configuration registers and the counters.
  localparam logic [TSP_W-1:0]  TARGET_PERIOD_RST = 20'd1000;
  localparam logic [CNT_W-1:0]  MAX_STEPS_RST     = 14'd10000;
  localparam logic [MINS_W-1:0] MIN_STEP_RST      = 20'd1;
  localparam logic [CNT_W-1:0]  COUNT_ONE         = 14'd1;

  localparam logic OP_QUERY   = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV1,
    S_CLAMP,
    S_PROD,
    S_DIV2S,
    S_DIV2,
    S_SUM,
    S_DIV3S,
    S_DIV3,
    S_RESULT
  } iete_state_t;

  // Which operands the shared divider takes when it starts.
  typedef enum logic [1:0] {
    DIV_RATIO,
    DIV_PART,
    DIV_EST
  } iete_div_sel_t;

  typedef struct packed {
    logic          accept;
    logic          div_start;
    iete_div_sel_t div_sel;
    logic          set_max;
    logic          scale;
    logic          clamp;
    logic          prod;
    logic          part;
    logic          sum;
    logic          commit;
    logic          emit;
  } iete_cmd_t;

  typedef struct packed {
    logic restart;
    logic resample;
    logic passed_pos;
    logic div_done;
    logic out_free;
  } iete_sts_t;

endpackage

[rtl/core/iete_ifs.sv]
interface iete_in_if;
  import iete_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [CLOCK_W-1:0] clock_now;

  modport source (output valid, output op, output clock_now, input ready);
  modport sink (input valid, input op, input clock_now, output ready);
endinterface

interface iete_out_if;
  import iete_pkg::*;

  logic                valid;
  logic                ready;
  logic [PASSED_W-1:0] passed_time;
  logic                resampled;

  modport source (output valid, output passed_time, output resampled, input ready);
  modport sink (input valid, input passed_time, input resampled, output ready);
endinterface

interface iete_cfg_if;
  import iete_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/interpolating_elapsed_time_estimator_unit.sv]
// A query that does not resample goes straight to the result state once it is accepted.
// A resampling query runs up to three divisions on one shared one-bit-per-cycle divider; the
// first division is skipped when the clock did not move forward. Either result is registered
// into the output register once that register is free.
// One item at a time: the next beat is taken the cycle after the result is loaded, a restart
// is taken in the idle state, and a result waiting on the consumer stalls the next query.
// Reset (rst_n low, synchronous) restores the register defaults and the estimator state, but not se_r.
module interpolating_elapsed_time_estimator_unit #(
  parameter int TIME_BITS = iete_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  iete_in_if.sink     in_ch,
  iete_out_if.source  out_ch,
  iete_cfg_if.sink    cfg_ch
);
  import iete_pkg::*;

  // The controller sequences one query: it accepts the beat, and when the
  // countdown runs out it walks the datapath through the resample. The
  // resample divides the target period by the measured interval, scales and
  // clamps it into a new countdown (the maximum if the clock did not move on),
  // then divides interval share and running balance to a per-query step.
  iete_cmd_t cmd;
  iete_sts_t sts;

  // Configuration writes are taken in any cycle. The source is to send them only while the
  // block is idle, so they never disturb a resample in flight; the block does not enforce this.
  assign cfg_ch.ready = 1'b1;

  iete_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the estimator state, the shared
  // divider and the output register. The output register lets the block take
  // the next beat while a finished result still waits for the consumer.
  iete_dp #(
    .TB (TIME_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_ch.op),
    .in_clock_now    (in_ch.clock_now),
    .cfg_valid       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_passed_time (out_ch.passed_time),
    .out_resampled   (out_ch.resampled)
  );

endmodule

[rtl/core/iete_div.sv]
module iete_div #(
  parameter int W = iete_pkg::TIME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         short_op,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  import iete_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;
  logic [W-1:0]  rem_shift;
  logic          ge;
  logic [W-1:0]  rem_nxt;

  // The remainder stays below the divisor, which is below 2^(W-1), so the
  // shifted remainder still fits in W bits.
  assign rem_shift = {rem_r[W-2:0], quo_r[W-1]};
  assign ge        = (rem_shift >= dvs_r);
  assign rem_nxt   = ge ? (rem_shift - dvs_r) : rem_shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= short_op ? CW'(TSP_W) : CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/core/iete_ctrl.sv]
module iete_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  iete_pkg::iete_sts_t sts,
  output iete_pkg::iete_cmd_t cmd
);
  import iete_pkg::*;

  iete_state_t state_r;
  iete_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_RATIO;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.restart) begin
            state_nxt = S_IDLE;
          end else if (sts.resample) begin
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_CHECK: begin
        if (sts.passed_pos) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RATIO;
          state_nxt     = S_DIV1;
        end else begin
          cmd.set_max = 1'b1;
          state_nxt   = S_PROD;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.scale = 1'b1;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_DIV2S;
      end
      S_DIV2S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_PART;
        state_nxt     = S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.part  = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DIV3S;
      end
      S_DIV3S: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_EST;
        state_nxt     = S_DIV3;
      end
      S_DIV3: begin
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/iete_dp.sv]
module iete_dp #(
  parameter int TB = iete_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  iete_pkg::iete_cmd_t             cmd,
  output iete_pkg::iete_sts_t             sts,
  input  logic                            in_op,
  input  logic [iete_pkg::CLOCK_W-1:0]    in_clock_now,
  input  logic                            cfg_valid,
  input  logic [iete_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iete_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [iete_pkg::PASSED_W-1:0]   out_passed_time,
  output logic                            out_resampled
);
  import iete_pkg::*;

  // Configuration registers.
  logic [TSP_W-1:0]  tsp_r;
  logic [CNT_W-1:0]  msc_r;
  logic [MINS_W-1:0] mins_r;

  // Estimator state.
  logic [CNT_W-1:0] countdown_r;
  logic [CNT_W-1:0] lsc_r;
  logic [TB-1:0]    bal_r;
  logic [TB-1:0]    last_r;
  logic [TB-1:0]    se_r;

  // Working registers of one resample.
  logic [TB-1:0]      now_r;
  logic [TB-1:0]      passed_r;
  logic [SCALE_W-1:0] q_r;
  logic [CNT_W-1:0]   next_r;
  logic [TB-1:0]      prod_r;
  logic [TB-1:0]      part_r;
  logic [TB-1:0]      sum_r;
  logic               div_neg_r;
  logic               took_r;

  logic                out_valid_r;
  logic [PASSED_W-1:0] out_pt_r;
  logic                out_rs_r;

  // Divider operands.
  logic          div_short;
  logic [TB-1:0] div_dividend;
  logic [TB-1:0] div_divisor;
  logic          div_neg_nxt;
  logic          div_done;
  logic [TB-1:0] div_quo;
  logic [TB-1:0] div_quo_s;

  logic [TB-1:0]      now_in;
  logic [CNT_W-1:0]   maxc;
  logic [CNT_W-1:0]   clamp_val;
  logic [SCALE_W-1:0] scale_full;
  logic [TB+CNT_W-1:0] prod_full;
  logic [CNT_W:0]     next_p1;
  logic [TB-1:0]      mins_ext;
  logic               est_low;
  logic [TB-1:0]      res;
  logic [63:0]        res64;

  assign now_in   = TB'(in_clock_now);
  assign maxc     = (msc_r == '0) ? COUNT_ONE : msc_r;
  assign next_p1  = {1'b0, next_r} + (CNT_W + 1)'(1);
  assign mins_ext = TB'(mins_r);

  assign scale_full = SCALE_W'(div_quo[TSP_W-1:0]) * SCALE_W'(lsc_r);
  assign prod_full  = (TB + CNT_W)'(passed_r) * (TB + CNT_W)'(next_r);

  // A zero ratio clamps up to one step, a large one down to the maximum.
  assign clamp_val = (q_r == '0) ? COUNT_ONE :
                     (q_r < SCALE_W'(maxc)) ? q_r[CNT_W-1:0] : maxc;

  // Signed dividends go through the divider as magnitudes; the quotient
  // takes the sign back afterwards, which truncates toward zero.
  always_comb begin
    div_short    = 1'b0;
    div_dividend = prod_r;
    div_divisor  = TB'(lsc_r);
    div_neg_nxt  = 1'b0;
    unique case (cmd.div_sel)
      DIV_RATIO: begin
        div_short    = 1'b1;
        div_dividend = {tsp_r, {(TB-TSP_W){1'b0}}};
        div_divisor  = passed_r;
      end
      DIV_PART: begin
        div_neg_nxt  = prod_r[TB-1];
        div_dividend = prod_r[TB-1] ? -prod_r : prod_r;
        div_divisor  = TB'(lsc_r);
      end
      DIV_EST: begin
        div_neg_nxt  = sum_r[TB-1];
        div_dividend = sum_r[TB-1] ? -sum_r : sum_r;
        div_divisor  = TB'(next_p1);
      end
      default: begin
        div_short = 1'b0;
      end
    endcase
  end

  assign div_quo_s = div_neg_r ? -div_quo : div_quo;

  // The reported step is never below the minimum step.
  assign est_low = ($signed(se_r) < $signed(mins_ext));
  assign res     = est_low ? mins_ext : se_r;
  assign res64   = 64'(res);

  iete_div #(
    .W (TB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .short_op (div_short),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsp_r       <= TARGET_PERIOD_RST;
      msc_r       <= MAX_STEPS_RST;
      mins_r      <= MIN_STEP_RST;
      countdown_r <= COUNT_ONE;
      lsc_r       <= COUNT_ONE;
      bal_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TARGET_PERIOD: tsp_r  <= cfg_data[TSP_W-1:0];
          CFG_MAX_STEPS:     msc_r  <= cfg_data[CNT_W-1:0];
          CFG_MIN_STEP:      mins_r <= cfg_data[MINS_W-1:0];
          default: begin
          end
        endcase
      end

      if (cmd.accept) begin
        if (in_op == OP_RESTART) begin
          countdown_r <= COUNT_ONE;
          lsc_r       <= COUNT_ONE;
          bal_r       <= '0;
          last_r      <= '0;
        end else begin
          countdown_r <= countdown_r - COUNT_ONE;
        end
      end

      if (cmd.prod) begin
        bal_r <= bal_r + passed_r;
      end

      if (cmd.commit) begin
        lsc_r       <= next_r;
        countdown_r <= next_r;
        last_r      <= now_r;
      end

      // A new result may replace one that the consumer takes in this cycle.
      if (cmd.emit) begin
        bal_r       <= bal_r - res;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r    <= now_in;
      passed_r <= now_in - last_r;
      took_r   <= (countdown_r == COUNT_ONE);
    end
    if (cmd.div_start) begin
      div_neg_r <= div_neg_nxt;
    end
    if (cmd.scale) begin
      q_r <= scale_full;
    end
    if (cmd.set_max) begin
      next_r <= maxc;
    end else if (cmd.clamp) begin
      next_r <= clamp_val;
    end
    if (cmd.prod) begin
      prod_r <= prod_full[TB-1:0];
    end
    if (cmd.part) begin
      part_r <= div_quo_s;
    end
    if (cmd.sum) begin
      sum_r <= part_r + bal_r;
    end
    if (cmd.commit) begin
      se_r <= div_quo_s;
    end
    if (cmd.emit) begin
      out_pt_r <= res64[PASSED_W-1:0];
      out_rs_r <= took_r;
    end
  end

  assign sts.restart    = (in_op == OP_RESTART);
  assign sts.resample   = (countdown_r == COUNT_ONE);
  assign sts.passed_pos = (passed_r != '0) && !passed_r[TB-1];
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_passed_time = out_pt_r;
  assign out_resampled   = out_rs_r;

endmodule

[test/tb_interpolating_elapsed_time_estimator_unit.sv]
`timescale 1ns / 1ps

module tb_interpolating_elapsed_time_estimator_unit;
  import iete_pkg::*;

  // Number of random phases, each with its own register setting.
  localparam int NUM_PHASES = 8;
  // Random beats sent per phase; together with the directed table this gives
  // roughly 1100 input beats.
  localparam int PHASE_BEATS = 135;
  // Cycles to let pass once nothing is expected any more. A trailing restart
  // makes no result, so this covers any work still under way.
  localparam int SETTLE_CYCLES = 200;
  // Length of the long stall on the result side.
  localparam int HOLD_CYCLES = 400;
  localparam int DIR_ROWS = 24;
  localparam logic [62:0] CLOCK_MAX = {CLOCK_W{1'b1}};

  // One result beat as the estimator reports it.
  typedef struct packed {
    logic [PASSED_W-1:0] passed;
    logic                resampled;
  } est_beat_t;

  // One row of the directed table. When has_lit is set, the expected result
  // is typed in right here; otherwise the estimator model supplies it.
  typedef struct packed {
    logic                op;
    logic [CLOCK_W-1:0]  clock_now;
    logic                has_lit;
    logic [PASSED_W-1:0] lit_passed;
    logic                lit_resampled;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  iete_in_if  in_ch ();
  iete_out_if out_ch ();
  iete_cfg_if cfg_ch ();

  interpolating_elapsed_time_estimator_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register copies held by the estimator model.
  logic [TSP_W-1:0]  r_period;
  logic [CNT_W-1:0]  r_max_steps;
  logic [MINS_W-1:0] r_min_step;

  // Estimator model state. All time values are 64-bit two's complement.
  logic [CNT_W-1:0] e_countdown;
  logic [CNT_W-1:0] e_last_steps;
  logic [63:0]      e_balance;
  logic [63:0]      e_last_sample;
  logic [63:0]      e_step;

  // Results still owed by the block, oldest first.
  est_beat_t owed_results[$];

  // Shared control between the stimulus and the result-side driver.
  logic idle_en = 1'b0;
  logic hold_req = 1'b0;

  int n_err = 0;
  int n_queries = 0;
  int n_restarts = 0;
  int n_results = 0;
  int n_resampled = 0;
  int n_reg_writes = 0;
  int n_holds = 0;

  est_beat_t got_beat;
  est_beat_t want_beat;

  // Signed 64-bit value over a positive divisor, truncating toward zero.
  function automatic logic [63:0] div_trunc(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] mag;
    if (num[63]) begin
      mag = -num;
      return -(mag / den);
    end
    return num / den;
  endfunction

  // Resample: pick the next countdown from the measured time passed, then
  // refresh the per-query step so that the balance is spread over it.
  function automatic void take_sample(input logic [CLOCK_W-1:0] now);
    logic [63:0] cap;
    logic [63:0] passed;
    logic [63:0] quot;
    logic [63:0] next;
    logic [63:0] part;
    cap = (r_max_steps == '0) ? 64'd1 : {{(64-CNT_W){1'b0}}, r_max_steps};
    passed = {1'b0, now} - e_last_sample;
    if (passed != 64'd0 && !passed[63]) begin
      quot = ({{(64-TSP_W){1'b0}}, r_period} / passed) * {{(64-CNT_W){1'b0}}, e_last_steps};
      next = (quot < cap) ? quot : cap;
      if (next < 64'd1) begin
        next = 64'd1;
      end
    end else begin
      // A clock that stood still or went backwards gives the widest spacing.
      next = cap;
    end
    e_balance = e_balance + passed;
    part = div_trunc(passed * next, {{(64-CNT_W){1'b0}}, e_last_steps});
    e_step = div_trunc(part + e_balance, next + 64'd1);
    e_last_steps = next[CNT_W-1:0];
    e_countdown = next[CNT_W-1:0];
    e_last_sample = {1'b0, now};
  endfunction

  // Advances the model by one accepted input beat. A restart yields nothing.
  function automatic void estimate_beat(input logic op, input logic [CLOCK_W-1:0] now,
                                        output logic has_res, output est_beat_t res);
    logic [63:0] floor_v;
    logic [63:0] report;
    has_res = 1'b0;
    res = '0;
    if (op == OP_RESTART) begin
      // The step estimate survives a restart on purpose.
      e_countdown = COUNT_ONE;
      e_last_steps = COUNT_ONE;
      e_balance = 64'd0;
      e_last_sample = 64'd0;
      return;
    end
    e_countdown = e_countdown - COUNT_ONE;
    if (e_countdown == '0) begin
      take_sample(now);
      res.resampled = 1'b1;
    end
    floor_v = {{(64-MINS_W){1'b0}}, r_min_step};
    report = ($signed(e_step) < $signed(floor_v)) ? floor_v : e_step;
    e_balance = e_balance - report;
    res.passed = report[PASSED_W-1:0];
    has_res = 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input logic [62:0] want,
                               input logic [62:0] got);
    n_err++;
    if (n_err <= 10) begin
      $display("[%0t] mismatch on %s: expected %0d (0x%h), got %0d (0x%h)",
               $time, what, want, want, got, got);
    end
  endtask

  // Result side: sample at the rising edge and compare with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_beat.passed = out_ch.passed_time;
      got_beat.resampled = out_ch.resampled;
      n_results++;
      if (got_beat.resampled) begin
        n_resampled++;
      end
      if (owed_results.size() == 0) begin
        note_mismatch("unexpected result beat", 63'd0, got_beat.passed);
      end else begin
        want_beat = owed_results.pop_front();
        if (got_beat.passed !== want_beat.passed) begin
          note_mismatch("passed_time", want_beat.passed, got_beat.passed);
        end
        if (got_beat.resampled !== want_beat.resampled) begin
          note_mismatch("resampled", {62'd0, want_beat.resampled},
                        {62'd0, got_beat.resampled});
        end
      end
    end
  end

  // Result-side ready. Random stalls while idling is on, and one long
  // hold-off on request, counted here in cycles, so the block backs up and
  // stalls its input while the sender keeps offering beats.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        n_holds++;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  // Writes one register. Called at a falling edge while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_TARGET_PERIOD: r_period = val[TSP_W-1:0];
      CFG_MAX_STEPS:     r_max_steps = val[CNT_W-1:0];
      CFG_MIN_STEP:      r_min_step = val[MINS_W-1:0];
      default: ;
    endcase
    n_reg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Offers one input beat from a falling edge and holds it until accepted.
  // Returns at the next falling edge with valid still high, unless a random
  // gap was inserted, so back-to-back beats never drop valid in between.
  task automatic send_beat(input logic op, input logic [CLOCK_W-1:0] now,
                           input logic has_lit, input est_beat_t lit);
    logic      has_res;
    est_beat_t res;
    in_ch.valid = 1'b1;
    in_ch.op = op;
    in_ch.clock_now = now;
    do @(posedge clk); while (!in_ch.ready);
    estimate_beat(op, now, has_res, res);
    if (has_res) begin
      owed_results.push_back(has_lit ? lit : res);
    end
    if (op == OP_RESTART) begin
      n_restarts++;
    end else begin
      n_queries++;
    end
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // Stops offering beats, waits until every owed result is in, then gives
  // any work that makes no result time to finish.
  task automatic drain_block();
    in_ch.valid = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Hard stop in case the block hangs.
  initial begin
    #36_000_000;
    $display("timeout: %0d results still owed", owed_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    dir_row_t           dir_tab [DIR_ROWS];
    logic [CFG_DATA_W-1:0] set_tab [NUM_PHASES][3];
    logic [CLOCK_W-1:0] clk_run;
    logic [63:0]        rnd64;
    int                 kind;
    est_beat_t          lit;

    // Directed beats under the reset register values. The first queries
    // resample with a period that matches the target exactly, so each step
    // equals the target; a query at clock zero right after a restart sees
    // no time passed and reports the minimum step.
    dir_tab = '{
      '{OP_QUERY,   63'd1000, 1'b1, 63'd1000, 1'b1},
      '{OP_QUERY,   63'd2000, 1'b1, 63'd1000, 1'b1},
      '{OP_RESTART, 63'd0,    1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd0,    1'b1, 63'd1,    1'b1},
      '{OP_QUERY,   63'd5,    1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd10,   1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd15,   1'b0, 63'd0,    1'b0},
      '{OP_RESTART, CLOCK_MAX, 1'b0, 63'd0,   1'b0},
      '{OP_QUERY,   CLOCK_MAX, 1'b0, 63'd0,   1'b0},
      '{OP_QUERY,   63'd0,    1'b0, 63'd0,    1'b0},
      '{OP_RESTART, 63'd0,    1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd100,  1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd200,  1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd300,  1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd400,  1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd500,  1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd600,  1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd700,  1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd800,  1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd900,  1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd1000, 1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'd1100, 1'b0, 63'd0,    1'b0},
      '{OP_QUERY,   63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 63'd0, 1'b0},
      '{OP_QUERY,   63'h5555_5555_5555_5555, 1'b0, 63'd0, 1'b0}
    };

    // Register settings per phase: target period, maximum step count and
    // minimum step. Reset values first, then all zeros, all ones, the
    // opposite extremes, a moderate setting, and random settings.
    set_tab[0] = '{20'd1000, 20'd10000, 20'd1};
    set_tab[1] = '{20'd0, 20'd0, 20'd0};
    set_tab[2] = '{20'hFFFFF, 20'd16383, 20'hFFFFF};
    set_tab[3] = '{20'd1000000, 20'd1, 20'd1000000};
    set_tab[4] = '{20'd1, 20'd16383, 20'd0};
    set_tab[5] = '{20'd5000, 20'd200, 20'd3};
    for (int p = 6; p < NUM_PHASES; p++) begin
      for (int r = 0; r < 3; r++) begin
        set_tab[p][r] = CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
      end
    end

    in_ch.valid = 1'b0;
    in_ch.op = OP_QUERY;
    in_ch.clock_now = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_TARGET_PERIOD;
    cfg_ch.data = '0;

    r_period = TARGET_PERIOD_RST;
    r_max_steps = MAX_STEPS_RST;
    r_min_step = MIN_STEP_RST;
    e_countdown = COUNT_ONE;
    e_last_steps = COUNT_ONE;
    e_balance = 64'd0;
    e_last_sample = 64'd0;
    // Never read before the first resample, which the reset countdown forces.
    e_step = 64'd0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, with idling on so gaps hit the first resamples too.
    idle_en = 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      lit.passed = dir_tab[i].lit_passed;
      lit.resampled = dir_tab[i].lit_resampled;
      send_beat(dir_tab[i].op, dir_tab[i].clock_now, dir_tab[i].has_lit, lit);
    end
    drain_block();

    // Random part. Most beats are queries whose clock moves forward by a
    // plausible amount, so the countdown and the balance really get used;
    // the rest are restarts, wild clock values and backward steps.
    clk_run = '0;
    lit = '0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_TARGET_PERIOD, set_tab[ph][0]);
      write_reg(CFG_MAX_STEPS, set_tab[ph][1]);
      write_reg(CFG_MIN_STEP, set_tab[ph][2]);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        // Idling comes and goes in stretches; the last phase runs flat out.
        if (k % 45 == 0) begin
          idle_en = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        if (ph == 1 && k == 50) begin
          hold_req = 1'b1;
        end
        // Sender pause until every owed result has arrived.
        if (k == 90) begin
          drain_block();
        end
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
          rnd64 = {$urandom, $urandom};
          send_beat(OP_RESTART, rnd64[CLOCK_W-1:0], 1'b0, lit);
        end else begin
          if (kind < 75) begin
            case ($urandom_range(0, 3))
              0: clk_run = clk_run + CLOCK_W'($urandom_range(0, 16));
              1: clk_run = clk_run + CLOCK_W'($urandom_range(0, 300));
              2: clk_run = clk_run + CLOCK_W'($urandom_range(0, 5000));
              default: clk_run = clk_run + CLOCK_W'($urandom_range(0, 2000000));
            endcase
          end else if (kind < 85) begin
            rnd64 = {$urandom, $urandom};
            clk_run = rnd64[CLOCK_W-1:0];
          end else if (kind < 95) begin
            clk_run = clk_run - CLOCK_W'($urandom_range(0, 3000));
          end else begin
            clk_run = CLOCK_MAX - CLOCK_W'($urandom_range(0, 100));
          end
          send_beat(OP_QUERY, clk_run, 1'b0, lit);
        end
      end
      drain_block();
    end

    while (owed_results.size() != 0) begin
      want_beat = owed_results.pop_front();
      note_mismatch("result never delivered", want_beat.passed, 63'd0);
    end

    $display("Covered %0d queries and %0d restarts over %0d register settings (%0d writes).",
             n_queries, n_restarts, NUM_PHASES + 1, n_reg_writes);
    $display("Checked %0d results, %0d of them resampled; %0d long output hold-off(s).",
             n_results, n_resampled, n_holds);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches in total", n_err);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/iete_pkg.sv
rtl/core/iete_ifs.sv
rtl/core/iete_div.sv
rtl/core/iete_ctrl.sv
rtl/core/iete_dp.sv
rtl/core/interpolating_elapsed_time_estimator_unit.sv
test/tb_interpolating_elapsed_time_estimator_unit.sv
